FILE: rtl/skep_pkg.sv
// Package for the serial key escape parser: event and mode types, the byte
// and key-name tables, and the trigger-sequence watch function.
// No dependencies.
package skep_pkg;

  localparam int unsigned NameLenW = 5;  // holds any name length up to 31
  localparam int unsigned WinLen   = 6;  // longest name that can match anything

  localparam logic [7:0] KeyAlpha   = 8'hc4;
  localparam logic [7:0] CharLBrack = 8'h5b;
  localparam logic [7:0] CharRBrack = 8'h5d;
  localparam logic [7:0] CharMinus  = 8'h2d;
  localparam logic [7:0] CharPlus   = 8'h2b;
  localparam logic [7:0] CaseOffset = 8'h20;
  localparam logic [2:0] TrigLastPos = 3'd6;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_COLLECT,
    MODE_SKIP
  } mode_e;

  typedef enum logic [2:0] {
    EV_KEY         = 3'd0,
    EV_HOLD_PRESS  = 3'd1,
    EV_HOLD_RELEASE = 3'd2,
    EV_CLEAR_MEM   = 3'd3,
    EV_MODE_TOGGLE = 3'd4,
    EV_ROW_TOGGLE  = 3'd5
  } ev_kind_e;

  typedef enum logic [3:0] {
    NM_NONE,
    NM_ON,
    NM_USER,
    NM_PRGM,
    NM_ALPHA,
    NM_SHIFT,
    NM_SST,
    NM_BST,
    NM_RS,
    NM_XEQ,
    NM_CLX,
    NM_XY,
    NM_RDN,
    NM_CLRMEM,
    NM_LEET
  } name_id_e;

  typedef logic [WinLen-1:0][7:0] name_win_t;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]       cnt;
    result_t [1:0]    item;
  } batch_t;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] code;
    logic [2:0] pos;
  } watch_t;

  // ASCII to keycode; lower case folds onto upper case.
  function automatic logic [7:0] byte_map(input logic [6:0] c);
    logic [6:0] k;
    logic [7:0] r;
    k = c;
    if (c inside {[7'h61:7'h7a]}) k = c - 7'h20;
    case (k)
      7'h01: r = 8'hc4;  7'h08: r = 8'hc3;  7'h0a: r = 8'h13;  7'h0d: r = 8'h13;
      7'h12: r = 8'h87;  7'h18: r = 8'h32;
      7'h20: r = 8'h37;  7'h23: r = 8'h71;  7'h24: r = 8'h83;  7'h25: r = 8'h31;
      7'h2a: r = 8'h16;  7'h2b: r = 8'h15;  7'h2c: r = 8'h77;  7'h2d: r = 8'h14;
      7'h2e: r = 8'h77;  7'h2f: r = 8'h17;
      7'h30: r = 8'h37;  7'h31: r = 8'h36;  7'h32: r = 8'h76;  7'h33: r = 8'h86;
      7'h34: r = 8'h35;  7'h35: r = 8'h75;  7'h36: r = 8'h85;  7'h37: r = 8'h34;
      7'h38: r = 8'h74;  7'h39: r = 8'h84;  7'h3a: r = 8'h17;  7'h3c: r = 8'h81;
      7'h3d: r = 8'h76;  7'h3e: r = 8'hc1;  7'h3f: r = 8'h86;
      7'h41: r = 8'h10;  7'h42: r = 8'h30;  7'h43: r = 8'h70;  7'h44: r = 8'h80;
      7'h45: r = 8'hc0;  7'h46: r = 8'h11;  7'h47: r = 8'h31;  7'h48: r = 8'h71;
      7'h49: r = 8'h81;  7'h4a: r = 8'hc1;  7'h4b: r = 8'h32;  7'h4c: r = 8'h72;
      7'h4d: r = 8'h82;  7'h4e: r = 8'h13;  7'h4f: r = 8'h73;
      7'h50: r = 8'h83;  7'h51: r = 8'h14;  7'h52: r = 8'h34;  7'h53: r = 8'h74;
      7'h54: r = 8'h84;  7'h55: r = 8'h15;  7'h56: r = 8'h35;  7'h57: r = 8'h75;
      7'h58: r = 8'h85;  7'h59: r = 8'h16;  7'h5a: r = 8'h36;  7'h5e: r = 8'h13;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] trig_at(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0: r = 8'h32;
      3'd1: r = 8'hc4;
      3'd2: r = 8'h72;
      3'd3: r = 8'hc0;
      3'd4: r = 8'hc0;
      3'd5: r = 8'h84;
      3'd6: r = 8'hc4;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Text t is right-justified: its first character sits in the top used byte.
  function automatic logic str_eq(input name_win_t s, input logic [NameLenW-1:0] len,
                                  input logic [8*WinLen-1:0] t, input logic [2:0] tlen);
    logic ok;
    ok = (len == NameLenW'(tlen));
    for (int i = 0; i < WinLen; i++) begin
      if (i < int'(tlen)) begin
        if (s[i] != t[8*(int'(tlen)-1-i) +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic name_id_e name_lookup(input name_win_t s,
                                           input logic [NameLenW-1:0] len);
    name_id_e id;
    id = NM_NONE;
    if (str_eq(s, len, 48'("ON"), 3'd2))     id = NM_ON;
    if (str_eq(s, len, 48'("USER"), 3'd4))   id = NM_USER;
    if (str_eq(s, len, 48'("PRGM"), 3'd4))   id = NM_PRGM;
    if (str_eq(s, len, 48'("ALPHA"), 3'd5))  id = NM_ALPHA;
    if (str_eq(s, len, 48'("SHIFT"), 3'd5))  id = NM_SHIFT;
    if (str_eq(s, len, 48'("SST"), 3'd3))    id = NM_SST;
    if (str_eq(s, len, 48'("BST"), 3'd3))    id = NM_BST;
    if (str_eq(s, len, 48'("RS"), 3'd2))     id = NM_RS;
    if (str_eq(s, len, 48'("XEQ"), 3'd3))    id = NM_XEQ;
    if (str_eq(s, len, 48'("CLX"), 3'd3))    id = NM_CLX;
    if (str_eq(s, len, 48'("XY"), 3'd2))     id = NM_XY;
    if (str_eq(s, len, 48'("RDN"), 3'd3))    id = NM_RDN;
    if (str_eq(s, len, 48'("CLRMEM"), 3'd6)) id = NM_CLRMEM;
    if (str_eq(s, len, 48'("LEET"), 3'd4))   id = NM_LEET;
    return id;
  endfunction

  function automatic logic [7:0] name_first(input name_id_e id);
    logic [7:0] r;
    case (id)
      NM_ON:    r = 8'h18;
      NM_USER:  r = 8'hc6;
      NM_PRGM:  r = 8'hc5;
      NM_ALPHA: r = 8'hc4;
      NM_SHIFT: r = 8'h12;
      NM_SST:   r = 8'hc2;
      NM_BST:   r = 8'h12;
      NM_RS:    r = 8'h87;
      NM_XEQ:   r = 8'h32;
      NM_CLX:   r = 8'hc3;
      NM_XY:    r = 8'h11;
      NM_RDN:   r = 8'h31;
      default:  r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] name_second(input name_id_e id);
    return (id == NM_BST) ? 8'hc2 : 8'h00;
  endfunction

  // One keycode through the trigger-sequence detector.
  function automatic watch_t watch(input logic [7:0] code, input logic special,
                                   input logic en, input logic [2:0] pos);
    watch_t w;
    logic [2:0] p;
    w.kind = EV_KEY;
    w.code = code;
    w.pos  = pos;
    if (en) begin
      p = (pos > TrigLastPos) ? 3'd0 : pos;
      if (code == trig_at(p)) begin
        if (p == TrigLastPos) begin
          w.pos  = 3'd0;
          w.kind = EV_MODE_TOGGLE;
          w.code = 8'h00;
        end else begin
          w.pos = p + 3'd1;
        end
      end else begin
        w.pos = (code == trig_at(3'd0)) ? 3'd1 : 3'd0;
        if (special && code == KeyAlpha) begin
          w.kind = EV_ROW_TOGGLE;
          w.code = 8'h00;
        end
      end
    end
    return w;
  endfunction

endpackage

FILE: rtl/skep_core.sv
// Parser state (bracket mode, name buffer, detector progress) and the
// single-pass decode of one byte into up to two results. Uses skep_pkg.
module skep_core #(
  parameter int unsigned NAME_BUFFER = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            special_i,
  input  logic            trig_en_i,
  output skep_pkg::batch_t batch_o
);

  localparam int unsigned LenW = $clog2(NAME_BUFFER);
  localparam logic [LenW-1:0] LenMax = LenW'(NAME_BUFFER - 1);

  skep_pkg::mode_e mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic [2:0]      pos_q, pos_d;
  logic [7:0]      name_q [NAME_BUFFER];

  logic                      wr_en;
  logic [7:0]                wr_char;
  skep_pkg::name_win_t       main_w, hold_w;
  logic [skep_pkg::NameLenW-1:0] len_ext, hold_len;
  skep_pkg::name_id_e        main_id, hold_id;
  logic [7:0]                hold_code, norm_code;
  skep_pkg::watch_t          w0, w1, wn;
  logic                      is_lb, is_rb;

  assign is_lb = (rx_byte_i == skep_pkg::CharLBrack);
  assign is_rb = (rx_byte_i == skep_pkg::CharRBrack);

  // next bracket mode
  always_comb begin
    mode_d = mode_q;
    if (fire_i) begin
      case (mode_q)
        skep_pkg::MODE_NORMAL: begin
          if (is_lb) mode_d = skep_pkg::MODE_COLLECT;
        end
        skep_pkg::MODE_COLLECT: begin
          if (is_lb) mode_d = skep_pkg::MODE_COLLECT;
          else if (is_rb) mode_d = skep_pkg::MODE_NORMAL;
          else if (len_q >= LenMax) mode_d = skep_pkg::MODE_SKIP;
        end
        skep_pkg::MODE_SKIP: begin
          if (is_lb) mode_d = skep_pkg::MODE_COLLECT;
          else if (is_rb) mode_d = skep_pkg::MODE_NORMAL;
        end
        default: mode_d = skep_pkg::MODE_NORMAL;
      endcase
    end
  end

  // name windows and lookups
  always_comb begin
    for (int i = 0; i < skep_pkg::WinLen; i++) begin
      main_w[i] = name_q[i];
      hold_w[i] = name_q[i+1];
    end
    len_ext  = skep_pkg::NameLenW'(len_q);
    hold_len = len_ext - skep_pkg::NameLenW'(1);
    main_id  = skep_pkg::name_lookup(main_w, len_ext);
    hold_id  = skep_pkg::name_lookup(hold_w, hold_len);
    case (hold_id)
      skep_pkg::NM_NONE, skep_pkg::NM_CLRMEM, skep_pkg::NM_LEET: begin
        if (hold_len == skep_pkg::NameLenW'(1) && !hold_w[0][7])
          hold_code = skep_pkg::byte_map(hold_w[0][6:0]);
        else
          hold_code = 8'h00;
      end
      skep_pkg::NM_ON: hold_code = 8'h00;
      default: begin
        hold_code = (skep_pkg::name_second(hold_id) != 8'h00) ? 8'h00
                                                               : skep_pkg::name_first(hold_id);
      end
    endcase
    norm_code = rx_byte_i[7] ? 8'h00 : skep_pkg::byte_map(rx_byte_i[6:0]);
    w0 = skep_pkg::watch(skep_pkg::name_first(main_id), special_i, trig_en_i, pos_q);
    w1 = skep_pkg::watch(skep_pkg::name_second(main_id), special_i, trig_en_i, w0.pos);
    wn = skep_pkg::watch(norm_code, special_i, trig_en_i, pos_q);
  end

  // outputs, name buffer and detector updates
  always_comb begin
    len_d   = len_q;
    pos_d   = pos_q;
    wr_en   = 1'b0;
    wr_char = rx_byte_i;
    if (rx_byte_i inside {[8'h61:8'h7a]}) wr_char = rx_byte_i - skep_pkg::CaseOffset;
    batch_o = '0;
    batch_o.item[0].kind = skep_pkg::EV_KEY;
    batch_o.item[1].kind = skep_pkg::EV_KEY;
    if (fire_i) begin
      if (mode_q == skep_pkg::MODE_NORMAL) begin
        if (is_lb) begin
          len_d = '0;
        end else if (norm_code != 8'h00) begin
          pos_d = wn.pos;
          batch_o.cnt = 2'd1;
          batch_o.item[0] = '{kind: wn.kind, code: wn.code, last: 1'b1};
        end
      end else if (is_lb || is_rb) begin
        len_d = '0;
        if (is_rb && mode_q == skep_pkg::MODE_COLLECT && len_q != '0) begin
          if (name_q[0] == skep_pkg::CharMinus) begin
            batch_o.cnt = 2'd1;
            batch_o.item[0] = '{kind: skep_pkg::EV_HOLD_RELEASE, code: 8'h00, last: 1'b1};
          end else if (name_q[0] == skep_pkg::CharPlus) begin
            if (hold_code != 8'h00) begin
              batch_o.cnt = 2'd1;
              batch_o.item[0] = '{kind: skep_pkg::EV_HOLD_PRESS, code: hold_code,
                                  last: 1'b1};
            end
          end else if (main_id == skep_pkg::NM_CLRMEM) begin
            batch_o.cnt = 2'd1;
            batch_o.item[0] = '{kind: skep_pkg::EV_CLEAR_MEM, code: 8'h00, last: 1'b1};
          end else if (main_id == skep_pkg::NM_LEET) begin
            batch_o.cnt = 2'd1;
            batch_o.item[0] = '{kind: skep_pkg::EV_MODE_TOGGLE, code: 8'h00, last: 1'b1};
          end else if (main_id != skep_pkg::NM_NONE) begin
            if (skep_pkg::name_second(main_id) != 8'h00) begin
              pos_d = w1.pos;
              batch_o.cnt = 2'd2;
              batch_o.item[0] = '{kind: w0.kind, code: w0.code, last: 1'b0};
              batch_o.item[1] = '{kind: w1.kind, code: w1.code, last: 1'b1};
            end else begin
              pos_d = w0.pos;
              batch_o.cnt = 2'd1;
              batch_o.item[0] = '{kind: w0.kind, code: w0.code, last: 1'b1};
            end
          end
        end
      end else if (mode_q == skep_pkg::MODE_COLLECT) begin
        if (len_q >= LenMax) begin
          len_d = '0;
        end else begin
          wr_en = 1'b1;
          len_d = len_q + LenW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= skep_pkg::MODE_NORMAL;
      len_q  <= '0;
      pos_q  <= 3'd0;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) name_q[len_q] <= wr_char;
  end

endmodule

FILE: rtl/skep_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per cycle
// while ready_i is high. Uses skep_pkg for the result and batch types.
module skep_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  skep_pkg::batch_t  batch_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output skep_pkg::result_t head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  skep_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q + PtrW'(batch_i.cnt);
    rptr_d = rptr_q + PtrW'(pop);
    cnt_d  = cnt_q + CntW'(batch_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_i.cnt != 2'd0) mem_q[wptr_q] <= batch_i.item[0];
    if (batch_i.cnt == 2'd2) mem_q[wptr_q + PtrW'(1)] <= batch_i.item[1];
  end

endmodule

FILE: rtl/serial_key_escape_parser.sv
// Top level of the serial key escape parser: APB register, input register,
// parser core and result queue. Uses skep_pkg, skep_core, skep_out_fifo.
//
//   channel   direction  handshake               payload
//   in        in         in_valid_i/in_ready_o   rx_byte_i, special_mode_active_i
//   out       out        out_valid_o/out_ready_i event_kind_o, key_code_o, last_of_run_o
//   cfg       in         psel/penable/pwrite     paddr, pwdata -> prdata (reg 0 at 0x0)
//
// A byte is registered, decoded once the result queue has room, and its
// results are registered in the queue; one byte per cycle is taken while the
// 4-entry result queue has room for two. With the output always ready no byte
// is held back: the only name that yields two results takes five bytes.
// Reset clears the bracket mode, name length, detector progress and queue.
// A stalled output holds the queue head; input stops once three results wait.
module serial_key_escape_parser #(
  parameter int unsigned NAME_BUFFER = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        special_mode_active_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  key_code_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              trig_en_q;
  logic              in_valid_q;
  logic [7:0]        rx_q;
  logic              spec_q;
  logic              fire;
  logic              room;
  skep_pkg::batch_t  batch;
  skep_pkg::result_t head;

  // register 0 decodes on the word address bit
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, trig_en_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_en_q <= 1'b0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      trig_en_q <= pwdata[0];
    end
  end

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_q   <= rx_byte_i;
      spec_q <= special_mode_active_i;
    end
  end

  skep_core #(
    .NAME_BUFFER(NAME_BUFFER)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .rx_byte_i (rx_q),
    .special_i (spec_q),
    .trig_en_i (trig_en_q),
    .batch_o   (batch)
  );

  skep_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign event_kind_o  = head.kind;
  assign key_code_o    = head.code;
  assign last_of_run_o = head.last;

endmodule

FILE: rtl/skep_checker.sv
// Port-level checks for serial_key_escape_parser, bound to the top level.
// Depends on the top level's ports and on skep_pkg for the event kinds.
module skep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] event_kind_o,
  input logic [7:0] key_code_o,
  input logic       last_of_run_o
);

  // a result waiting for the consumer stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
                                    && $stable(key_code_o))
    else $error("result dropped or changed while stalled");

  // the second result of a byte is queued together with the first
  a_run_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o && last_of_run_o)
    else $error("first of a run not followed by its last result");

  // key and hold-press kinds carry a real keycode, other kinds carry zero
  a_code_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_kind_o == skep_pkg::EV_KEY
                      || event_kind_o == skep_pkg::EV_HOLD_PRESS) ? key_code_o != 8'h00
                                                                  : key_code_o == 8'h00))
    else $error("keycode does not match event kind");

  // a run of two comes only from a named pair; its head is a key or toggle kind
  a_run_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> event_kind_o == skep_pkg::EV_KEY
                                      || event_kind_o == skep_pkg::EV_MODE_TOGGLE
                                      || event_kind_o == skep_pkg::EV_ROW_TOGGLE)
    else $error("unexpected kind at head of a two-result run");

endmodule

bind serial_key_escape_parser skep_checker u_skep_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_kind_o  (event_kind_o),
  .key_code_o    (key_code_o),
  .last_of_run_o (last_of_run_o)
);

FILE: tb/serial_key_escape_parser_test.sv
`timescale 1ns / 1ps
// Self-checking bench for serial_key_escape_parser: directed rows, then random byte streams,
// scored against this module's model of the escape parser or a directed row's own results.
// Depends on skep_pkg and the serial_key_escape_parser RTL.
module serial_key_escape_parser_test;

  localparam int          HalfPeriod  = 5;
  localparam int          NameBuf     = 8;
  localparam int          CycleLimit  = 500_000;
  localparam int          DrainCycles = 10;
  localparam int          PhaseItems  = 300;
  localparam int          NumPhases   = 6;
  localparam logic [2:0]  AddrTrigEn  = 3'd0;
  localparam logic [2:0]  AddrUnused  = 3'd4;

  typedef enum logic { ROW_BYTE, ROW_CFG } row_op_e;

  typedef struct {
    row_op_e              op;
    logic [2:0]           addr;
    logic [7:0]           data;
    logic                 spec;
    int                   n;      // -1: take the model's results
    skep_pkg::ev_kind_e   k0;
    logic [7:0]           c0;
    skep_pkg::ev_kind_e   k1;
    logic [7:0]           c1;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        special_mode_active_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [7:0]  key_code_o;
  logic        last_of_run_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  serial_key_escape_parser #(.NAME_BUFFER(NameBuf)) uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .rx_byte_i, .special_mode_active_i,
    .out_valid_o, .out_ready_i, .event_kind_o, .key_code_o, .last_of_run_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Keycode tables of the parser
  logic [7:0] key_map [128] = '{
    8'h00, 8'hc4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hc3, 8'h00, 8'h13, 8'h00, 8'h00, 8'h13, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h87, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h37, 8'h00, 8'h00, 8'h71, 8'h83, 8'h31, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h16, 8'h15, 8'h77, 8'h14, 8'h77, 8'h17,
    8'h37, 8'h36, 8'h76, 8'h86, 8'h35, 8'h75, 8'h85, 8'h34,
    8'h74, 8'h84, 8'h17, 8'h00, 8'h81, 8'h76, 8'hc1, 8'h86,
    8'h00, 8'h10, 8'h30, 8'h70, 8'h80, 8'hc0, 8'h11, 8'h31,
    8'h71, 8'h81, 8'hc1, 8'h32, 8'h72, 8'h82, 8'h13, 8'h73,
    8'h83, 8'h14, 8'h34, 8'h74, 8'h84, 8'h15, 8'h35, 8'h75,
    8'h85, 8'h16, 8'h36, 8'h00, 8'h00, 8'h00, 8'h13, 8'h00,
    8'h00, 8'h10, 8'h30, 8'h70, 8'h80, 8'hc0, 8'h11, 8'h31,
    8'h71, 8'h81, 8'hc1, 8'h32, 8'h72, 8'h82, 8'h13, 8'h73,
    8'h83, 8'h14, 8'h34, 8'h74, 8'h84, 8'h15, 8'h35, 8'h75,
    8'h85, 8'h16, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  string      key_text   [12] = '{"ON", "USER", "PRGM", "ALPHA", "SHIFT", "SST",
                                  "BST", "RS", "XEQ", "CLX", "XY", "RDN"};
  logic [7:0] key_first  [12] = '{8'h18, 8'hc6, 8'hc5, 8'hc4, 8'h12, 8'hc2,
                                  8'h12, 8'h87, 8'h32, 8'hc3, 8'h11, 8'h31};
  logic [7:0] key_second [12] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                  8'hc2, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  logic [7:0] trig_seq   [7]  = '{8'h32, 8'hc4, 8'h72, 8'hc0, 8'hc0, 8'h84, 8'hc4};

  // Model state
  logic            trig_en = 1'b0;
  skep_pkg::mode_e mode = skep_pkg::MODE_NORMAL;
  int              nm_count = 0;
  logic [7:0]      nm_chars [NameBuf];
  int              trig_pos = 0;

  skep_pkg::result_t byte_events [$];
  skep_pkg::result_t pending_events [$];
  row_t              stim_table [$];
  logic [7:0]        burst [$];

  int mismatches = 0;
  int cycles = 0;
  int items_sent = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  function automatic void add_event(input skep_pkg::ev_kind_e k, input logic [7:0] c);
    skep_pkg::result_t r;
    r.kind = k;
    r.code = c;
    r.last = 1'b0;
    if (byte_events.size() < 2) byte_events.push_back(r);
  endfunction

  function automatic bit name_is(input int start, input int len, input string t);
    int i;
    if (len != t.len()) return 1'b0;
    for (i = 0; i < len; i++)
      if (nm_chars[start + i] != t[i]) return 1'b0;
    return 1'b1;
  endfunction

  // One keycode through the trigger-sequence watch
  function automatic void watch_push(input logic [7:0] code, input logic spec);
    if (trig_en) begin
      if (trig_pos > 6) trig_pos = 0;
      if (code == trig_seq[trig_pos]) begin
        trig_pos++;
        if (trig_pos == 7) begin
          trig_pos = 0;
          add_event(skep_pkg::EV_MODE_TOGGLE, 8'h00);
          return;
        end
      end else begin
        trig_pos = (code == trig_seq[0]) ? 1 : 0;
        if (spec && code == skep_pkg::KeyAlpha) begin
          add_event(skep_pkg::EV_ROW_TOGGLE, 8'h00);
          return;
        end
      end
    end
    add_event(skep_pkg::EV_KEY, code);
  endfunction

  function automatic logic [7:0] hold_key(input int len);
    int i;
    if (name_is(1, len, "ON")) return 8'h00;
    for (i = 0; i < 12; i++)
      if (name_is(1, len, key_text[i])) return (key_second[i] != 0) ? 8'h00 : key_first[i];
    if (len == 1 && nm_chars[1] < 8'h80) return key_map[nm_chars[1][6:0]];
    return 8'h00;
  endfunction

  function automatic void finish_name(input logic spec);
    logic [7:0] c;
    int i;
    if (nm_count == 0) return;
    if (nm_chars[0] == skep_pkg::CharMinus) begin
      add_event(skep_pkg::EV_HOLD_RELEASE, 8'h00);
    end else if (nm_chars[0] == skep_pkg::CharPlus) begin
      c = hold_key(nm_count - 1);
      if (c != 0) add_event(skep_pkg::EV_HOLD_PRESS, c);
    end else if (name_is(0, nm_count, "CLRMEM")) begin
      add_event(skep_pkg::EV_CLEAR_MEM, 8'h00);
    end else if (name_is(0, nm_count, "LEET")) begin
      add_event(skep_pkg::EV_MODE_TOGGLE, 8'h00);
    end else begin
      for (i = 0; i < 12; i++) begin
        if (name_is(0, nm_count, key_text[i])) begin
          watch_push(key_first[i], spec);
          if (key_second[i] != 0) watch_push(key_second[i], spec);
          return;
        end
      end
    end
  endfunction

  // Advance the model by one input item; its results land in byte_events
  function automatic void decode_byte(input logic [7:0] b, input logic spec);
    logic [7:0] ch;
    ch = b;
    byte_events.delete();
    if (mode == skep_pkg::MODE_NORMAL) begin
      if (ch == skep_pkg::CharLBrack) begin
        mode = skep_pkg::MODE_COLLECT;
        nm_count = 0;
      end else if (ch < 8'h80 && key_map[ch[6:0]] != 0) begin
        watch_push(key_map[ch[6:0]], spec);
      end
    end else if (ch == skep_pkg::CharLBrack) begin
      mode = skep_pkg::MODE_COLLECT;
      nm_count = 0;
    end else if (ch == skep_pkg::CharRBrack) begin
      if (mode == skep_pkg::MODE_COLLECT) finish_name(spec);
      mode = skep_pkg::MODE_NORMAL;
      nm_count = 0;
    end else if (mode == skep_pkg::MODE_COLLECT) begin
      if (nm_count >= NameBuf - 1) begin
        mode = skep_pkg::MODE_SKIP;
        nm_count = 0;
      end else begin
        if (ch >= "a" && ch <= "z") ch = ch - skep_pkg::CaseOffset;
        nm_chars[nm_count] = ch;
        nm_count++;
      end
    end
  endfunction

  function automatic void queue_events();
    int k;
    for (k = 0; k < byte_events.size(); k++) begin
      byte_events[k].last = (k == byte_events.size() - 1);
      pending_events.push_back(byte_events[k]);
    end
  endfunction

  // Directed table builders
  function automatic void add_byte(input logic [7:0] b, input logic spec, input int n,
                                   input skep_pkg::ev_kind_e k0 = skep_pkg::EV_KEY,
                                   input logic [7:0] c0 = 8'h00,
                                   input skep_pkg::ev_kind_e k1 = skep_pkg::EV_KEY,
                                   input logic [7:0] c1 = 8'h00);
    row_t r;
    r.op = ROW_BYTE;
    r.addr = AddrTrigEn;
    r.data = b;
    r.spec = spec;
    r.n = n;
    r.k0 = k0;
    r.c0 = c0;
    r.k1 = k1;
    r.c1 = c1;
    stim_table.push_back(r);
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i], 1'b0, -1);
  endfunction

  function automatic void add_cfg(input logic [2:0] a, input logic [7:0] v);
    row_t r;
    r.op = ROW_CFG;
    r.addr = a;
    r.data = v;
    r.spec = 1'b0;
    r.n = -1;
    r.k0 = skep_pkg::EV_KEY;
    r.c0 = 8'h00;
    r.k1 = skep_pkg::EV_KEY;
    r.c1 = 8'h00;
    stim_table.push_back(r);
  endfunction

  // Random stream builders; letters get a random case
  function automatic void push_text(input string s);
    int i;
    logic [7:0] ch;
    for (i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")) && $urandom_range(0, 1))
        ch = ch ^ skep_pkg::CaseOffset;
      burst.push_back(ch);
    end
  endfunction

  function automatic void push_code(input logic [7:0] code);
    int hits [$];
    int i;
    int pick;
    pick = -1;
    for (i = 0; i < 128; i++)
      if (key_map[i] == code) hits.push_back(i);
    for (i = 0; i < 12; i++)
      if (key_first[i] == code && key_second[i] == 0) pick = i;
    if (pick >= 0 && (hits.size() == 0 || $urandom_range(0, 3) == 0)) begin
      burst.push_back(skep_pkg::CharLBrack);
      push_text(key_text[pick]);
      burst.push_back(skep_pkg::CharRBrack);
    end else if (hits.size() != 0) begin
      burst.push_back(8'(hits[$urandom_range(0, hits.size() - 1)]));
    end
  endfunction

  function automatic void build_burst();
    int r;
    int i;
    int len;
    burst.delete();
    r = $urandom_range(0, 99);
    if (r < 25) begin
      burst.push_back(8'($urandom_range(0, 127)));
    end else if (r < 35) begin
      burst.push_back(8'($urandom_range(0, 255)));
    end else if (r < 70) begin
      burst.push_back(skep_pkg::CharLBrack);
      case ($urandom_range(0, 7))
        0, 1: push_text(key_text[$urandom_range(0, 11)]);
        2: push_text("CLRMEM");
        3: push_text("LEET");
        4: begin
          burst.push_back(skep_pkg::CharPlus);
          push_text(key_text[$urandom_range(0, 11)]);
        end
        5: begin
          burst.push_back(skep_pkg::CharPlus);
          burst.push_back(8'($urandom_range(33, 126)));
        end
        6: begin
          burst.push_back(skep_pkg::CharMinus);
          len = $urandom_range(0, 6);
          for (i = 0; i < len; i++) burst.push_back(8'($urandom_range(0, 127)));
        end
        default: begin
          len = $urandom_range(0, 9);
          for (i = 0; i < len; i++) burst.push_back(8'("A" + $urandom_range(0, 25)));
        end
      endcase
      burst.push_back(skep_pkg::CharRBrack);
    end else if (r < 90) begin
      // trigger run; now and then break it with a stray byte
      for (i = 0; i < 7; i++) begin
        if ($urandom_range(0, 11) == 0) burst.push_back(8'($urandom_range(0, 127)));
        else push_code(trig_seq[i]);
      end
    end else begin
      burst.push_back(skep_pkg::CharLBrack);
      len = $urandom_range(0, 10);
      for (i = 0; i < len; i++) burst.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) burst.push_back(skep_pkg::CharRBrack);
    end
  endfunction

  // Present one item and return at the edge that accepts it
  task automatic send_byte(input logic [7:0] b, input logic spec);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    special_mode_active_i <= spec;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] d,
                            output logic [31:0] rd);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    if (pready !== 1'b1) flag($sformatf("pready: expected 1, got %b", pready));
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drain the block, write a register, read the trigger-enable register back
  task automatic change_config(input logic [2:0] a, input logic [7:0] v);
    logic [31:0] rd;
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    apb_access(1'b1, a, {24'd0, v}, rd);
    if (a == AddrTrigEn) trig_en = v[0];
    apb_access(1'b0, AddrTrigEn, 32'd0, rd);
    if (rd !== {31'd0, trig_en})
      flag($sformatf("trigger_enable read: expected %0d, got %h", trig_en, rd));
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[serial_key_escape_parser] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, score every accepted item against the oldest prediction
  initial begin
    int stall;
    skep_pkg::result_t e;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      if (pending_events.size() == 0) begin
        flag($sformatf("unexpected result: kind %0d code %h last %b",
                       event_kind_o, key_code_o, last_of_run_o));
      end else begin
        e = pending_events.pop_front();
        if (event_kind_o !== e.kind || key_code_o !== e.code || last_of_run_o !== e.last)
          flag($sformatf("result: expected kind %0d code %h last %b, got kind %0d code %h last %b",
                         e.kind, e.code, e.last, event_kind_o, key_code_o, last_of_run_o));
      end
      @(posedge clk_i);
    end
  end

  initial begin
    int i;
    int p;
    logic spec;
    row_t r;
    skep_pkg::result_t t;

    for (i = 0; i < NameBuf; i++) nm_chars[i] = 8'h00;

    // directed rows
    add_byte(8'h00, 1'b0, 0);
    add_byte(8'hff, 1'b1, 0);
    add_byte("A", 1'b0, 1, skep_pkg::EV_KEY, 8'h10);
    add_text("[clrmem");
    add_byte(skep_pkg::CharRBrack, 1'b0, 1, skep_pkg::EV_CLEAR_MEM);
    add_text("[leet");
    add_byte(skep_pkg::CharRBrack, 1'b1, 1, skep_pkg::EV_MODE_TOGGLE);
    add_text("[-x");
    add_byte(skep_pkg::CharRBrack, 1'b0, 1, skep_pkg::EV_HOLD_RELEASE);
    add_text("[x[+a");  // fresh bracket drops the first name
    add_byte(skep_pkg::CharRBrack, 1'b0, 1, skep_pkg::EV_HOLD_PRESS, 8'h10);
    add_text("[bst");
    add_byte(skep_pkg::CharRBrack, 1'b0, 2, skep_pkg::EV_KEY, 8'h12,
             skep_pkg::EV_KEY, 8'hc2);
    add_text("[abcdefgh[]");  // overlong name skipped, then an empty name
    add_byte(skep_pkg::CharLBrack, 1'b0, -1);
    add_byte(8'h00, 1'b0, -1);
    add_byte(8'hff, 1'b1, -1);
    add_byte(skep_pkg::CharRBrack, 1'b0, 0);
    add_cfg(AddrUnused, 8'h01);
    add_cfg(AddrTrigEn, 8'h01);
    add_text("KL");
    stim_table[stim_table.size() - 1].data = 8'h01;  // K, then ALPHA via ^A
    add_text("L");
    add_cfg(AddrTrigEn, 8'h00);  // progress must hold across this
    add_text("E");
    add_cfg(AddrTrigEn, 8'h01);
    add_text("EET");
    add_byte(8'h01, 1'b0, 1, skep_pkg::EV_MODE_TOGGLE);
    add_byte(8'h01, 1'b1, 1, skep_pkg::EV_ROW_TOGGLE);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < stim_table.size(); i++) begin
      r = stim_table[i];
      if (r.op == ROW_CFG) begin
        change_config(r.addr, r.data);
      end else begin
        send_byte(r.data, r.spec);
        decode_byte(r.data, r.spec);
        if (r.n >= 0) begin
          byte_events.delete();
          if (r.n >= 1) begin
            t.kind = r.k0;
            t.code = r.c0;
            t.last = 1'b0;
            byte_events.push_back(t);
          end
          if (r.n >= 2) begin
            t.kind = r.k1;
            t.code = r.c1;
            byte_events.push_back(t);
          end
        end
        queue_events();
      end
    end

    // random phases, register changed between them
    for (p = 0; p < NumPhases; p++) begin
      change_config(AddrTrigEn, (p < 2) ? 8'(p[0] ^ 1'b1) : 8'($urandom_range(0, 1)));
      items_sent = 0;
      while (items_sent < PhaseItems) begin
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        build_burst();
        for (i = 0; i < burst.size(); i++) begin
          spec = $urandom_range(0, 1);
          send_byte(burst[i], spec);
          decode_byte(burst[i], spec);
          queue_events();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (2 * DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[serial_key_escape_parser] OK");
    end else begin
      $display("[serial_key_escape_parser] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/skep_pkg.sv
rtl/skep_core.sv
rtl/skep_out_fifo.sv
rtl/serial_key_escape_parser.sv
rtl/skep_checker.sv
tb/serial_key_escape_parser_test.sv
